FILE: hw/rtl/eatn_pkg.sv
// Package for the embedding analogy top-N search block.
// Holds channel payload types, chain cell types, register codes and widths.
// No dependencies.
package eatn_pkg;

    localparam int MAX_WORDS_DEF = 1024;
    localparam int MAX_DIM_DEF   = 256;
    localparam int TOP_N_DEF     = 40;

    localparam int WORD_W    = 10;
    localparam int COMP_W    = 8;
    localparam int VALUE_W   = 16;
    localparam int RANK_W    = 6;
    localparam int SCORE_W   = 32;
    localparam int WIU_W     = 11;
    localparam int VLEN_W    = 9;
    localparam int CFG_W     = 11;

    // q = s - f + t of three Q1.14 values
    localparam int Q_W       = 18;
    localparam int SQ_W      = 2 * Q_W;
    localparam int SUMSQ_W   = 44;
    localparam int ROOT_W    = SUMSQ_W / 2;
    localparam int PROD_W    = Q_W + VALUE_W;
    localparam int ACC_W     = 44;
    localparam int NUM_W     = ACC_W + 2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic CFG_WORDS_IN_USE  = 1'b0;
    localparam logic CFG_VECTOR_LENGTH = 1'b1;

    typedef struct packed {
        logic                       command;
        logic [WORD_W-1:0]          load_word;
        logic [COMP_W-1:0]          load_component;
        logic signed [VALUE_W-1:0]  load_value;
        logic [WORD_W-1:0]          first_index;
        logic [WORD_W-1:0]          second_index;
        logic [WORD_W-1:0]          third_index;
    } in_t;

    typedef struct packed {
        logic [RANK_W-1:0]          rank;
        logic [WORD_W-1:0]          word_index;
        logic signed [SCORE_W-1:0]  score;
        logic                       error;
        logic                       last;
    } out_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0]  score;
        logic [WORD_W-1:0]          word;
    } cell_t;

    typedef struct packed {
        logic ins;
        logic shift;
    } cell_ctl_t;

endpackage

FILE: hw/rtl/eatn_ram.sv
// Generic simple dual-port RAM with registered read.
// One write port, one read port. No dependencies.
module eatn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/eatn_cell.sv
// One slot of the sorted best-score chain.
// Depends on eatn_pkg for the cell payload and control types.
module eatn_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  eatn_pkg::cell_ctl_t ctl,
    input  eatn_pkg::cell_t   cand,
    input  logic              prev_gt,
    input  eatn_pkg::cell_t   prev_data,
    input  eatn_pkg::cell_t   next_data,
    output logic              gt,
    output eatn_pkg::cell_t   data
);

    eatn_pkg::cell_t slot_reg;

    assign gt   = ctl.ins && (cand.score > slot_reg.score);
    assign data = slot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
        end else if (ctl.shift) begin
            // advance toward the head while results drain
            slot_reg <= next_data;
        end else if (gt) begin
            // take the candidate at the insert point, push the rest down
            slot_reg <= prev_gt ? prev_data : cand;
        end
    end

endmodule

FILE: hw/rtl/eatn_sqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on nothing but its parameters.
module eatn_sqrt #(
    parameter int IN_W = 44,
    localparam int RW  = IN_W / 2,
    localparam int CW  = $clog2(RW + 1)
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [IN_W-1:0] x,
    output logic            done,
    output logic [RW-1:0]   root
);

    logic            busy_reg;
    logic            done_reg;
    logic [CW-1:0]   cnt_reg;
    logic [IN_W-1:0] x_reg;
    logic [RW+1:0]   rem_reg;
    logic [RW-1:0]   root_reg;
    logic [RW+1:0]   rem_sh;
    logic [RW+1:0]   trial;

    assign rem_sh = {rem_reg[RW-1:0], x_reg[IN_W-1:IN_W-2]};
    assign trial  = {root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                x_reg    <= x;
                rem_reg  <= '0;
                root_reg <= '0;
            end else if (busy_reg) begin
                x_reg <= {x_reg[IN_W-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[RW-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[RW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(RW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: hw/rtl/eatn_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero,
// with saturation of the quotient to 32 signed bits. No dependencies.
module eatn_div #(
    parameter int NUM_W = 46,
    parameter int DEN_W = 22,
    localparam int CW   = $clog2(NUM_W + 1)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic                    done,
    output logic signed [31:0]      quo
);

    logic               busy_reg;
    logic               fin_reg;
    logic               done_reg;
    logic [CW-1:0]      cnt_reg;
    logic               neg_reg;
    logic [NUM_W-1:0]   q_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [DEN_W-1:0]   den_reg;
    logic signed [31:0] quo_reg;
    logic [DEN_W:0]     rem_sh;
    logic [DEN_W:0]     diff;

    assign rem_sh = {rem_reg, q_reg[NUM_W-1]};
    assign diff   = rem_sh - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                neg_reg  <= num[NUM_W-1];
                q_reg    <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
                rem_reg  <= '0;
                den_reg  <= den;
            end else if (busy_reg) begin
                if (rem_sh >= {1'b0, den_reg}) begin
                    rem_reg <= diff[DEN_W-1:0];
                    q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh[DEN_W-1:0];
                    q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end else if (fin_reg) begin
                // clamp the magnitude into the signed 32-bit range
                if (!neg_reg) begin
                    quo_reg <= (q_reg > NUM_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                               : $signed(q_reg[31:0]);
                end else begin
                    quo_reg <= (q_reg > NUM_W'(32'h8000_0000)) ? 32'sh8000_0000
                                                               : -$signed(q_reg[31:0]);
                end
                done_reg <= 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

FILE: hw/rtl/embedding_analogy_top_n_core.sv
// Embedding analogy search: table RAM, query RAM, root and divide units,
// sequencer and a chain of sorted best-score cells. Depends on eatn_pkg.
//
// Usage: s_ (input) and m_ (result) channels use valid/ready; a transaction
// completes when both are high. A load transaction (command 0) writes one
// table component and is taken at one per cycle while the block is idle.
// A query (command 1) is taken only when idle; while it runs s_ready is low.
// A bad query index gives one error result. Otherwise the query runs:
//   vector build per component, then square root,
//   then for each searched word fetch and dot product and division
//   (a query word itself is skipped; a zero root skips the search),
//   then TOP_N results, one per cycle while m_ready allows.
// Throughput is set by the single read port of the table RAM and by the
// bit-serial divider shared over all words.
// The result register holds a result while m_ready is low; the block holds
// back the next. Reset (aresetn low, synchronous) clears the control
// state and the best list and restores words_in_use and vector_length;
// table contents stay undefined until loaded. Configuration writes
// (cfg_wr_en, cfg_index, cfg_wr_data) take effect in the next cycle.
module embedding_analogy_top_n_core #(
    parameter int MAX_WORDS = eatn_pkg::MAX_WORDS_DEF,
    parameter int MAX_DIM   = eatn_pkg::MAX_DIM_DEF,
    parameter int TOP_N     = eatn_pkg::TOP_N_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  eatn_pkg::in_t                 s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output eatn_pkg::out_t                m_data,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [eatn_pkg::CFG_W-1:0]    cfg_wr_data
);

    localparam int WW        = $clog2(MAX_WORDS);
    localparam int CW        = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int EMB_DEPTH = MAX_WORDS * (2 ** CW);
    localparam int WIU_RST_I = (MAX_WORDS < 1024) ? MAX_WORDS : 1024;
    localparam int VL_RST_I  = (MAX_DIM < 256) ? MAX_DIM : 256;
    localparam logic [eatn_pkg::WIU_W-1:0]  WIU_RST = eatn_pkg::WIU_W'(WIU_RST_I);
    localparam logic [eatn_pkg::VLEN_W-1:0] VL_RST  = eatn_pkg::VLEN_W'(VL_RST_I);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ERR   = 4'd1;
    localparam logic [3:0] ST_QV    = 4'd2;
    localparam logic [3:0] ST_SQRT  = 4'd3;
    localparam logic [3:0] ST_WORD  = 4'd4;
    localparam logic [3:0] ST_DOT   = 4'd5;
    localparam logic [3:0] ST_DRAIN = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_EMIT  = 4'd8;

    logic [3:0]                            state_reg, state_next;
    logic [2:0]                            ph_reg;
    logic [eatn_pkg::VLEN_W-1:0]           i_reg;
    logic [eatn_pkg::WIU_W-1:0]            c_reg;
    logic [eatn_pkg::RANK_W-1:0]           k_reg;
    logic [eatn_pkg::WORD_W-1:0]           f_reg, s_reg, t_reg;
    logic [eatn_pkg::WIU_W-1:0]            wiu_reg;
    logic [eatn_pkg::VLEN_W-1:0]           vlen_reg;
    logic signed [eatn_pkg::Q_W-1:0]       accq_reg, q_reg;
    logic signed [eatn_pkg::SQ_W-1:0]      sq_reg;
    logic [eatn_pkg::SUMSQ_W-1:0]          sumsq_reg, sumsq_sum;
    logic [eatn_pkg::ROOT_W-1:0]           root_reg, sqrt_root;
    logic                                  v1_reg, v2_reg;
    logic signed [eatn_pkg::PROD_W-1:0]    prod_reg;
    logic signed [eatn_pkg::ACC_W-1:0]     acc_reg;
    logic                                  m_valid_reg;
    eatn_pkg::out_t                        m_data_reg;

    logic                                  in_acc, out_free, last_comp, bad_idx, skip;
    logic                                  emb_we, qv_we, sqrt_start, sqrt_done;
    logic                                  div_start, div_done;
    logic signed [31:0]                    div_quo;
    logic [eatn_pkg::WIU_W-1:0]            word_sel;
    logic [WW+CW-1:0]                      emb_waddr, emb_raddr;
    logic [eatn_pkg::VALUE_W-1:0]          emb_rdata;
    logic [eatn_pkg::Q_W-1:0]              qv_rdata;
    logic [eatn_pkg::WIU_W-1:0]            wiu_clamp;
    logic [eatn_pkg::VLEN_W-1:0]           vlen_clamp;
    eatn_pkg::cell_ctl_t                   cell_ctl;
    eatn_pkg::cell_t                       cand;
    eatn_pkg::cell_t                       dq [TOP_N+2];
    logic [TOP_N:0]                        gt_chain;
    logic                                  sorted_ok;

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_acc    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign last_comp = (i_reg == vlen_reg - 1'b1);

    assign bad_idx = (s_data.first_index == '0) || (s_data.second_index == '0)
                  || (s_data.third_index == '0)
                  || ({1'b0, s_data.first_index} >= wiu_reg)
                  || ({1'b0, s_data.second_index} >= wiu_reg)
                  || ({1'b0, s_data.third_index} >= wiu_reg);

    assign skip = (c_reg == {1'b0, f_reg}) || (c_reg == {1'b0, s_reg})
               || (c_reg == {1'b0, t_reg});

    // config clamping into the legal ranges
    always_comb begin
        if (cfg_wr_data == '0) begin
            wiu_clamp = eatn_pkg::WIU_W'(1);
        end else if (32'(cfg_wr_data) > 32'(MAX_WORDS)) begin
            wiu_clamp = eatn_pkg::WIU_W'(MAX_WORDS);
        end else begin
            wiu_clamp = cfg_wr_data;
        end
        if (cfg_wr_data[eatn_pkg::VLEN_W-1:0] == '0) begin
            vlen_clamp = eatn_pkg::VLEN_W'(1);
        end else if (32'(cfg_wr_data[eatn_pkg::VLEN_W-1:0]) > 32'(MAX_DIM)) begin
            vlen_clamp = eatn_pkg::VLEN_W'(MAX_DIM);
        end else begin
            vlen_clamp = cfg_wr_data[eatn_pkg::VLEN_W-1:0];
        end
    end

    always_comb begin
        word_sel = c_reg;
        if (state_reg == ST_QV) begin
            case (ph_reg)
                3'd0:    word_sel = {1'b0, s_reg};
                3'd1:    word_sel = {1'b0, f_reg};
                default: word_sel = {1'b0, t_reg};
            endcase
        end
    end

    assign emb_we = in_acc && (s_data.command == eatn_pkg::CMD_LOAD)
                 && (32'(s_data.load_word) < 32'(MAX_WORDS))
                 && (32'(s_data.load_component) < 32'(MAX_DIM));
    assign emb_waddr = {WW'(s_data.load_word), CW'(s_data.load_component)};
    assign emb_raddr = {WW'(word_sel), CW'(i_reg)};

    eatn_ram #(.WIDTH(eatn_pkg::VALUE_W), .DEPTH(EMB_DEPTH)) u_emb_ram (
        .aclk  (aclk),
        .we    (emb_we),
        .waddr (emb_waddr),
        .wdata (s_data.load_value),
        .raddr (emb_raddr),
        .rdata (emb_rdata)
    );

    assign qv_we = (state_reg == ST_QV) && (ph_reg == 3'd4);

    eatn_ram #(.WIDTH(eatn_pkg::Q_W), .DEPTH(MAX_DIM)) u_qv_ram (
        .aclk  (aclk),
        .we    (qv_we),
        .waddr (CW'(i_reg)),
        .wdata (q_reg),
        .raddr (CW'(i_reg)),
        .rdata (qv_rdata)
    );

    assign sumsq_sum  = sumsq_reg + eatn_pkg::SUMSQ_W'($unsigned(sq_reg));
    assign sqrt_start = (state_reg == ST_QV) && (ph_reg == 3'd5) && last_comp;

    eatn_sqrt #(.IN_W(eatn_pkg::SUMSQ_W)) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .x       (sumsq_sum),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    assign div_start = (state_reg == ST_DRAIN) && !v1_reg && !v2_reg;

    eatn_div #(.NUM_W(eatn_pkg::NUM_W), .DEN_W(eatn_pkg::ROOT_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     ($signed({acc_reg, 2'b00})),
        .den     (root_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign cell_ctl.ins   = (state_reg == ST_DIV) && div_done;
    assign cell_ctl.shift = (state_reg == ST_EMIT) && out_free;
    assign cand.score     = div_quo;
    assign cand.word      = c_reg[eatn_pkg::WORD_W-1:0];

    assign dq[0]         = '0;
    assign dq[TOP_N+1]   = '0;
    assign gt_chain[0]   = 1'b0;

    for (genvar g = 0; g < TOP_N; g++) begin : g_cell
        eatn_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (cell_ctl),
            .cand      (cand),
            .prev_gt   (gt_chain[g]),
            .prev_data (dq[g]),
            .next_data (dq[g+2]),
            .gt        (gt_chain[g+1]),
            .data      (dq[g+1])
        );
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc && s_data.command == eatn_pkg::CMD_QUERY) begin
                    state_next = bad_idx ? ST_ERR : ST_QV;
                end
            end
            ST_ERR:   if (out_free) state_next = ST_IDLE;
            ST_QV:    if (sqrt_start) state_next = ST_SQRT;
            ST_SQRT: begin
                if (sqrt_done) begin
                    state_next = (sqrt_root == '0) ? ST_EMIT : ST_WORD;
                end
            end
            ST_WORD: begin
                if (c_reg == wiu_reg) begin
                    state_next = ST_EMIT;
                end else if (!skip) begin
                    state_next = ST_DOT;
                end
            end
            ST_DOT:   if (last_comp) state_next = ST_DRAIN;
            ST_DRAIN: if (div_start) state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_WORD;
            ST_EMIT: begin
                if (out_free && k_reg == eatn_pkg::RANK_W'(TOP_N - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            wiu_reg     <= WIU_RST;
            vlen_reg    <= VL_RST;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                case (cfg_index)
                    eatn_pkg::CFG_WORDS_IN_USE:  wiu_reg  <= wiu_clamp;
                    eatn_pkg::CFG_VECTOR_LENGTH: vlen_reg <= vlen_clamp;
                    default: ;
                endcase
            end

            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // dot-product pipe: read, multiply, accumulate
            v1_reg   <= (state_reg == ST_DOT);
            v2_reg   <= v1_reg;
            prod_reg <= $signed(qv_rdata) * $signed(emb_rdata);
            if (v2_reg) begin
                acc_reg <= acc_reg + eatn_pkg::ACC_W'(prod_reg);
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_acc && s_data.command == eatn_pkg::CMD_QUERY) begin
                        f_reg     <= s_data.first_index;
                        s_reg     <= s_data.second_index;
                        t_reg     <= s_data.third_index;
                        i_reg     <= '0;
                        ph_reg    <= '0;
                        sumsq_reg <= '0;
                    end
                end
                ST_ERR: begin
                    if (out_free) begin
                        m_valid_reg           <= 1'b1;
                        m_data_reg.rank       <= '0;
                        m_data_reg.word_index <= '0;
                        m_data_reg.score      <= '0;
                        m_data_reg.error      <= 1'b1;
                        m_data_reg.last       <= 1'b1;
                    end
                end
                ST_QV: begin
                    case (ph_reg)
                        3'd1:    accq_reg <= eatn_pkg::Q_W'($signed(emb_rdata));
                        3'd2:    accq_reg <= accq_reg
                                             - eatn_pkg::Q_W'($signed(emb_rdata));
                        3'd3:    q_reg    <= accq_reg
                                             + eatn_pkg::Q_W'($signed(emb_rdata));
                        3'd4:    sq_reg   <= q_reg * q_reg;
                        default: ;
                    endcase
                    if (ph_reg == 3'd5) begin
                        sumsq_reg <= sumsq_sum;
                        ph_reg    <= '0;
                        if (!last_comp) begin
                            i_reg <= i_reg + 1'b1;
                        end
                    end else begin
                        ph_reg <= ph_reg + 1'b1;
                    end
                end
                ST_SQRT: begin
                    if (sqrt_done) begin
                        root_reg <= sqrt_root;
                        c_reg    <= '0;
                        k_reg    <= '0;
                    end
                end
                ST_WORD: begin
                    if (c_reg == wiu_reg) begin
                        k_reg <= '0;
                    end else if (skip) begin
                        c_reg <= c_reg + 1'b1;
                    end else begin
                        acc_reg <= '0;
                        i_reg   <= '0;
                    end
                end
                ST_DOT: begin
                    if (!last_comp) begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        c_reg <= c_reg + 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg           <= 1'b1;
                        m_data_reg.rank       <= k_reg;
                        m_data_reg.word_index <= dq[1].word;
                        m_data_reg.score      <= dq[1].score;
                        m_data_reg.error      <= 1'b0;
                        m_data_reg.last       <= (k_reg == eatn_pkg::RANK_W'(TOP_N - 1));
                        k_reg                 <= k_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        sorted_ok = 1'b1;
        for (int n = 1; n < TOP_N; n++) begin
            if (dq[n].score < dq[n+1].score) begin
                sorted_ok = 1'b0;
            end
        end
    end

    a_sorted: assert property (@(posedge aclk) disable iff (!aresetn) sorted_ok)
        else $error("best list out of order");

    a_div_root: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> root_reg != '0)
        else $error("divide started with zero root");

    a_err_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error |-> m_data.last && m_data.rank == '0)
        else $error("error result not single");

    a_unfilled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.error && m_data.score <= 0
        |-> m_data.word_index == '0 && m_data.score == 0)
        else $error("non-positive score in filled slot");

endmodule

FILE: verif/analogy_checker.sv
// Checker for the embedding analogy search: watches the configuration port and both
// channels, predicts ranked results and compares them. Depends on eatn_pkg.
`timescale 1ns / 100ps
module analogy_checker
    import eatn_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  in_t              s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  out_t             m_data,
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_wr_data,
    output int               fail_count,
    output int               pending
);

    shortint emb_table [0:MAX_WORDS_DEF-1][0:MAX_DIM_DEF-1];
    int      query_vec [0:MAX_DIM_DEF-1];
    int      words_lim;
    int      vec_len;
    out_t    ranked_q[$];

    initial begin
        fail_count = 0;
        pending    = 0;
        words_lim  = MAX_WORDS_DEF;
        vec_len    = MAX_DIM_DEF;
    end

    function automatic int clamp_int(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint unsigned isqrt64(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic rank_analogy(input in_t it);
        int              f;
        int              s;
        int              t;
        int              sc;
        int              best_sc [TOP_N_DEF];
        int              best_wd [TOP_N_DEF];
        longint unsigned sumsq;
        longint          root;
        longint          dot;
        longint          num;
        out_t            r;
        f = it.first_index;
        s = it.second_index;
        t = it.third_index;
        if (f == 0 || s == 0 || t == 0 || f >= words_lim || s >= words_lim
                || t >= words_lim) begin
            r = '0;
            r.error = 1'b1;
            r.last  = 1'b1;
            ranked_q.push_back(r);
            return;
        end
        sumsq = 0;
        for (int i = 0; i < vec_len; i++) begin
            query_vec[i] = int'(emb_table[s][i]) - int'(emb_table[f][i])
                         + int'(emb_table[t][i]);
            sumsq += longint'(query_vec[i]) * longint'(query_vec[i]);
        end
        root = longint'(isqrt64(sumsq));
        for (int a = 0; a < TOP_N_DEF; a++) begin
            best_sc[a] = 0;
            best_wd[a] = 0;
        end
        if (root != 0) begin
            for (int c = 0; c < words_lim; c++) begin
                if (c == f || c == s || c == t) continue;
                dot = 0;
                for (int i = 0; i < vec_len; i++)
                    dot += longint'(query_vec[i]) * longint'(emb_table[c][i]);
                num = (dot * 4) / root;
                if (num > 64'sd2147483647) sc = 32'h7fffffff;
                else if (num < -64'sd2147483648) sc = 32'h80000000;
                else sc = int'(num);
                // insert ahead of the first strictly lower entry
                for (int a = 0; a < TOP_N_DEF; a++) begin
                    if (sc > best_sc[a]) begin
                        for (int d = TOP_N_DEF - 1; d > a; d--) begin
                            best_sc[d] = best_sc[d-1];
                            best_wd[d] = best_wd[d-1];
                        end
                        best_sc[a] = sc;
                        best_wd[a] = c;
                        break;
                    end
                end
            end
        end
        for (int k = 0; k < TOP_N_DEF; k++) begin
            r.rank       = RANK_W'(k);
            r.word_index = WORD_W'(best_wd[k]);
            r.score      = best_sc[k];
            r.error      = 1'b0;
            r.last       = (k == TOP_N_DEF - 1);
            ranked_q.push_back(r);
        end
    endtask

    always @(posedge aclk) begin
        out_t exp_r;
        if (!aresetn) begin
            words_lim = MAX_WORDS_DEF;
            vec_len   = MAX_DIM_DEF;
            ranked_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (ranked_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transaction: %p", m_data);
                end else begin
                    exp_r = ranked_q.pop_front();
                    if (m_data !== exp_r) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result mismatch: expected %p actual %p", exp_r, m_data);
                    end
                end
            end
            if (cfg_wr_en) begin
                if (cfg_index == CFG_WORDS_IN_USE)
                    words_lim = clamp_int(int'(cfg_wr_data[WIU_W-1:0]), 1, MAX_WORDS_DEF);
                else
                    vec_len = clamp_int(int'(cfg_wr_data[VLEN_W-1:0]), 1, MAX_DIM_DEF);
            end
            if (s_valid && s_ready) begin
                if (s_data.command == CMD_LOAD)
                    emb_table[s_data.load_word][s_data.load_component] = s_data.load_value;
                else
                    rank_analogy(s_data);
            end
        end
        pending = ranked_q.size();
    end

endmodule

FILE: verif/testbench.sv
// Top of the analogy search testbench: clock, reset, load and query stimulus,
// configuration phases and verdict. Depends on eatn_pkg, the core and analogy_checker.
`timescale 1ns / 100ps
module testbench;
    import eatn_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    in_t              s_data;
    logic             m_valid;
    logic             m_ready;
    out_t             m_data;
    logic             cfg_wr_en;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_wr_data;
    int               fail_count;
    int               pending;
    int               cycles;
    int               burst_left;
    int               stall_mode;
    int               stall_left;
    int               cur_words;
    int               cur_len;
    int               phase_words;
    int               phase_len;
    bit               loaded [0:MAX_WORDS_DEF-1][0:MAX_DIM_DEF-1];

    embedding_analogy_top_n_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
    );

    analogy_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver stall pattern: free-running, light or heavy stalling
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 120);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    task automatic send_item(input in_t it);
        int gap;
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
        end else begin
            burst_left--;
        end
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    task automatic load_comp(input int w, input int p, input logic [VALUE_W-1:0] v);
        in_t it;
        it                = in_t'({$urandom, $urandom, $urandom});
        it.command        = CMD_LOAD;
        it.load_word      = WORD_W'(w);
        it.load_component = COMP_W'(p);
        it.load_value     = v;
        loaded[w][p]      = 1'b1;
        send_item(it);
    endtask

    task automatic run_query(input int f, input int s, input int t);
        in_t it;
        it              = in_t'({$urandom, $urandom, $urandom});
        it.command      = CMD_QUERY;
        it.first_index  = WORD_W'(f);
        it.second_index = WORD_W'(s);
        it.third_index  = WORD_W'(t);
        send_item(it);
    endtask

    // fill every entry a query under the current setting can read
    task automatic fill_region();
        for (int w = 0; w < cur_words; w++)
            for (int p = 0; p < cur_len; p++)
                if (!loaded[w][p]) load_comp(w, p, pick_value());
    endtask

    task automatic drain_idle();
        if (s_valid) s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input int v, input int eff);
        drain_idle();
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= CFG_W'(v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_WORDS_IN_USE) cur_words = eff;
        else cur_len = eff;
    endtask

    function automatic int valid_word();
        return $urandom_range(1, cur_words - 1);
    endfunction

    task automatic random_query();
        int idx [3];
        for (int i = 0; i < 3; i++) idx[i] = valid_word();
        if ($urandom_range(0, 6) == 0) begin
            // break one index: zero or past the words in use
            if ($urandom_range(0, 1) == 0 || cur_words >= MAX_WORDS_DEF)
                idx[$urandom_range(0, 2)] = 0;
            else
                idx[$urandom_range(0, 2)] = $urandom_range(cur_words, MAX_WORDS_DEF - 1);
        end
        run_query(idx[0], idx[1], idx[2]);
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = CFG_WORDS_IN_USE;
        cfg_wr_data = '0;
        cycles      = 0;
        burst_left  = 0;
        stall_mode  = 0;
        stall_left  = 0;
        cur_words   = MAX_WORDS_DEF;
        cur_len     = MAX_DIM_DEF;
        phase_words = 0;
        phase_len   = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults: extreme loads and an error query that reads nothing
        load_comp(MAX_WORDS_DEF - 1, MAX_DIM_DEF - 1, 16'h8000);
        load_comp(MAX_WORDS_DEF - 1, MAX_DIM_DEF - 2, 16'h7fff);
        run_query(0, 1, 2);

        write_reg(CFG_WORDS_IN_USE, 8, 8);
        write_reg(CFG_VECTOR_LENGTH, 4, 4);
        fill_region();
        for (int p = 0; p < 4; p++) load_comp(2, p, 16'h0000);
        run_query(5, 6, 7);
        run_query(3, 3, 2);      // zero-length query vector
        run_query(0, 1, 2);
        run_query(1, 0, 2);
        run_query(1, 2, 0);
        run_query(8, 1, 2);      // index at words in use
        run_query(1, 1023, 2);
        run_query(1, 1, 1);
        run_query(7, 7, 7);
        run_query(4, 1, 6);

        // out-of-range register values saturate
        write_reg(CFG_WORDS_IN_USE, 0, 1);
        write_reg(CFG_VECTOR_LENGTH, 0, 1);
        run_query(1, 1, 1);
        run_query(0, 0, 0);

        // full-size settings: only queries that stop at the index check
        write_reg(CFG_WORDS_IN_USE, 2047, MAX_WORDS_DEF);
        write_reg(CFG_VECTOR_LENGTH, 511, MAX_DIM_DEF);
        run_query(0, 1023, 5);

        for (int ph = 0; ph < 4; ph++) begin
            phase_words = $urandom_range(4, 10);
            phase_len   = $urandom_range(1, 4);
            write_reg(CFG_WORDS_IN_USE, phase_words, phase_words);
            write_reg(CFG_VECTOR_LENGTH, phase_len, phase_len);
            fill_region();
            for (int n = 0; n < 40; n++) begin
                if ($urandom_range(0, 9) < 6) begin
                    // rewrite inside the region or touch anywhere in the table
                    if ($urandom_range(0, 1) == 0)
                        load_comp($urandom_range(0, cur_words - 1),
                                  $urandom_range(0, cur_len - 1), pick_value());
                    else
                        load_comp($urandom_range(0, MAX_WORDS_DEF - 1),
                                  $urandom_range(0, MAX_DIM_DEF - 1), pick_value());
                end else begin
                    random_query();
                end
            end
        end

        drain_idle();
        repeat (100) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
